// File: hdl/stag_pkg.sv
`timescale 1ns / 1ps
package stag_pkg;

  localparam int unsigned RANK_MAX   = 4;
  localparam int unsigned DIM_BITS   = 16;
  localparam int unsigned INDEX_BITS = 32;
  localparam int unsigned SRC_BITS   = 35;
  localparam int unsigned CFG_BITS   = 64;
  localparam int unsigned RANK_BITS  = $clog2(RANK_MAX + 1);
  localparam int unsigned DSEL_BITS  = (RANK_MAX > 1) ? $clog2(RANK_MAX) : 1;

  localparam logic [1:0] REG_BASE    = 2'd0;
  localparam logic [1:0] REG_RANK    = 2'd1;
  localparam logic [1:0] REG_SIZES   = 2'd2;
  localparam logic [1:0] REG_STRIDES = 2'd3;

  typedef struct packed {
    logic [31:0] element_index;
    logic        last_in_run;
  } in_t;

  typedef struct packed {
    logic [34:0] source_index;
    logic        bad_shape;
    logic        last_out;
  } out_t;

  // word moving down the cell chain
  typedef struct packed {
    logic                  last;
    logic [INDEX_BITS-1:0] x;
    logic [DIM_BITS-1:0]   r;
    logic [SRC_BITS-1:0]   sum;
  } stage_t;

  // per-dimension control seen by every cell of one slot
  typedef struct packed {
    logic                active;
    logic [DIM_BITS-1:0] size;
    logic [DIM_BITS-1:0] stride;
  } ctl_t;

endpackage

// File: hdl/stag_div_cell.sv
`timescale 1ns / 1ps
module stag_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stag_pkg::ctl_t   ctl_i,
  input  logic            valid_i,
  input  stag_pkg::stage_t stage_i,
  output logic            valid_o,
  output stag_pkg::stage_t stage_o
);

  logic [stag_pkg::DIM_BITS:0] t;
  logic                        ge;
  stag_pkg::stage_t            stage_d, stage_q;
  logic                        valid_q;

  // one restoring-division step: shift in the next dividend bit
  always_comb begin
    t       = {stage_i.r, stage_i.x[stag_pkg::INDEX_BITS-1]};
    ge      = (t >= {1'b0, ctl_i.size});
    stage_d = stage_i;
    if (ctl_i.active) begin
      stage_d.r = ge ? stag_pkg::DIM_BITS'(t - {1'b0, ctl_i.size})
                     : stag_pkg::DIM_BITS'(t);
      stage_d.x = {stage_i.x[stag_pkg::INDEX_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// File: hdl/stag_mac_cell.sv
`timescale 1ns / 1ps
module stag_mac_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stag_pkg::ctl_t   ctl_i,
  input  logic            valid_i,
  input  stag_pkg::stage_t stage_i,
  output logic            valid_o,
  output stag_pkg::stage_t stage_o
);

  logic [2*stag_pkg::DIM_BITS-1:0] prod;
  stag_pkg::stage_t                stage_d, stage_q;
  logic                            valid_q;

  // remainder times stride into the sum; quotient moves on as the next index
  always_comb begin
    prod    = {{stag_pkg::DIM_BITS{1'b0}}, stage_i.r}
            * {{stag_pkg::DIM_BITS{1'b0}}, ctl_i.stride};
    stage_d = stage_i;
    if (ctl_i.active) begin
      stage_d.sum = stage_i.sum + stag_pkg::SRC_BITS'(prod);
      stage_d.r   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// File: hdl/strided_tensor_address_generator.sv
`timescale 1ns / 1ps
// From start to valid_o: input register, the cells of every slot, output register.
// Throughput: one word per cycle; busy is never raised, the cell chain is fully pipelined.
// Each dimension costs INDEX_BITS one-bit divide cells plus one multiply-add cell.
// Reset: asynchronous, active low; clears the config to base 0, rank 1, sizes and strides
// 1 in dim 0, 0 elsewhere; drops every word in flight. The receiver cannot stall.
module strided_tensor_address_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  stag_pkg::in_t                 in_i,
  output logic                          valid_o,
  output stag_pkg::out_t                out_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [stag_pkg::CFG_BITS-1:0] cfg_data_i
);

  localparam int unsigned CPS = stag_pkg::INDEX_BITS + 1;
  localparam int unsigned NST = stag_pkg::RANK_MAX * CPS;

  logic [31:0] base_q;
  logic [2:0]  rank_q;
  logic [63:0] sizes_q, strides_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      rank_q    <= 3'd1;
      sizes_q   <= 64'd1;
      strides_q <= 64'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stag_pkg::REG_BASE:    base_q    <= cfg_data_i[31:0];
        stag_pkg::REG_RANK:    rank_q    <= cfg_data_i[2:0];
        stag_pkg::REG_SIZES:   sizes_q   <= cfg_data_i;
        stag_pkg::REG_STRIDES: strides_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [stag_pkg::DIM_BITS-1:0] size_a   [stag_pkg::RANK_MAX];
  logic [stag_pkg::DIM_BITS-1:0] stride_a [stag_pkg::RANK_MAX];

  for (genvar d = 0; d < stag_pkg::RANK_MAX; d++) begin : g_fld
    if ((d + 1) * stag_pkg::DIM_BITS <= 64) begin : g_in
      assign size_a[d]   = sizes_q[d*stag_pkg::DIM_BITS +: stag_pkg::DIM_BITS];
      assign stride_a[d] = strides_q[d*stag_pkg::DIM_BITS +: stag_pkg::DIM_BITS];
    end else if (d * stag_pkg::DIM_BITS < 64) begin : g_part
      assign size_a[d]   = stag_pkg::DIM_BITS'(sizes_q >> (d * stag_pkg::DIM_BITS));
      assign stride_a[d] = stag_pkg::DIM_BITS'(strides_q >> (d * stag_pkg::DIM_BITS));
    end else begin : g_out
      assign size_a[d]   = '0;
      assign stride_a[d] = '0;
    end
  end

  logic [stag_pkg::RANK_BITS-1:0] rank_eff;
  always_comb begin
    if ({1'b0, rank_q} > 4'(stag_pkg::RANK_MAX)) begin
      rank_eff = stag_pkg::RANK_BITS'(stag_pkg::RANK_MAX);
    end else begin
      rank_eff = stag_pkg::RANK_BITS'(rank_q);
    end
  end

  logic bad;
  always_comb begin
    bad = 1'b0;
    for (int d = 0; d < stag_pkg::RANK_MAX; d++) begin
      if ((stag_pkg::RANK_BITS'(d) < rank_eff) && (size_a[d] == '0)) bad = 1'b1;
    end
  end

  // slot k walks dimension rank-1-k, so the innermost goes first
  stag_pkg::ctl_t ctl [stag_pkg::RANK_MAX];
  for (genvar k = 0; k < stag_pkg::RANK_MAX; k++) begin : g_ctl
    logic [stag_pkg::RANK_BITS-1:0] dk;
    assign dk            = rank_eff - stag_pkg::RANK_BITS'(k + 1);
    assign ctl[k].active = stag_pkg::RANK_BITS'(k) < rank_eff;
    assign ctl[k].size   = size_a[dk[stag_pkg::DSEL_BITS-1:0]];
    assign ctl[k].stride = stride_a[dk[stag_pkg::DSEL_BITS-1:0]];
  end

  logic             vld [NST+1];
  stag_pkg::stage_t stg [NST+1];
  logic             in_vld_q;
  stag_pkg::stage_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q.last <= in_i.last_in_run;
    in_q.x    <= stag_pkg::INDEX_BITS'(in_i.element_index);
    in_q.r    <= '0;
    in_q.sum  <= stag_pkg::SRC_BITS'(base_q);
  end

  assign vld[0] = in_vld_q;
  assign stg[0] = in_q;

  for (genvar k = 0; k < stag_pkg::RANK_MAX; k++) begin : g_slot
    for (genvar b = 0; b < stag_pkg::INDEX_BITS; b++) begin : g_div
      stag_div_cell u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl[k]),
        .valid_i (vld[k*CPS+b]),
        .stage_i (stg[k*CPS+b]),
        .valid_o (vld[k*CPS+b+1]),
        .stage_o (stg[k*CPS+b+1])
      );
    end
    stag_mac_cell u_mac (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[k]),
      .valid_i (vld[k*CPS+stag_pkg::INDEX_BITS]),
      .stage_i (stg[k*CPS+stag_pkg::INDEX_BITS]),
      .valid_o (vld[(k+1)*CPS]),
      .stage_o (stg[(k+1)*CPS])
    );
  end

  logic           out_vld_q;
  stag_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.source_index <= bad ? '0 : stg[NST].sum;
    out_q.bad_shape    <= bad;
    out_q.last_out     <= stg[NST].last;
  end

  assign busy    = 1'b0;
  assign valid_o = out_vld_q;
  assign out_o   = out_q;

endmodule
